// ===== sv/scb_pkg.sv =====
package scb_pkg;

    localparam int COORD_BITS     = 12;
    localparam int SIDE_BITS      = 6;
    localparam int CHUNK_SIDE     = 1 << SIDE_BITS;
    localparam int CHUNK_IDX_BITS = 2 * (COORD_BITS - SIDE_BITS);
    localparam int NUM_CHUNKS     = 1 << CHUNK_IDX_BITS;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_WIPE  = 2'd3;

    localparam logic [1:0] TAG_EMPTY   = 2'd0;
    localparam logic [1:0] TAG_FULL    = 2'd1;
    localparam logic [1:0] TAG_PARTIAL = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] column;
    } cmd_t;

    typedef struct packed {
        logic bit_value;
        logic status;
    } rsp_t;

endpackage

// ===== sv/scb_ram.sv =====
module scb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sparse_chunked_bitmap_unit.sv =====
// Sparse 4096 x 4096 bitmap built from 64 x 64 chunks. Each chunk is tagged
// empty, full or partial in a tag memory; only partial chunks own a slot of
// 64 words x 64 bits from a pool of POOL_CHUNKS slots, handed out from a free
// stack. One transaction is worked at a time and gives exactly one response.
// Get reads the tag and, on a partial chunk, then the word. Set or clear
// that converts an empty or full chunk takes a new slot, which is zeroed or
// filled one word per cycle. Set or clear on a partial chunk does a
// read-modify-write of the word, then a scan of all 64 words through the
// single read port of the word memory to see whether the slot can be freed.
// Clear-whole-map sweeps the tag memory and rebuilds the free stack, one
// entry per cycle. The same sweep runs after reset, with no response, while
// the command channel is stalled. If the pool is empty when a slot is
// needed, the transaction is dropped with status 1.
module sparse_chunked_bitmap_unit #(
    parameter int POOL_CHUNKS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  scb_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output scb_pkg::rsp_t rsp
);

    localparam int SLOT_BITS  = POOL_CHUNKS > 1 ? $clog2(POOL_CHUNKS) : 1;
    localparam int FREE_BITS  = $clog2(POOL_CHUNKS + 1);
    localparam int WADDR_BITS = SLOT_BITS + scb_pkg::SIDE_BITS;
    localparam int CIDX       = scb_pkg::CHUNK_IDX_BITS;
    localparam int SB         = scb_pkg::SIDE_BITS;
    localparam int CW         = scb_pkg::CHUNK_SIDE;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOOK  = 4'd1;
    localparam logic [3:0] ST_GETW  = 4'd2;
    localparam logic [3:0] ST_FILL  = 4'd3;
    localparam logic [3:0] ST_MODR  = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_SCANE = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;
    localparam logic [3:0] ST_SWEEP = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [CIDX-1:0]      ci_reg, ci_next;
    logic [SB-1:0]        wi_reg, wi_next;
    logic [SB-1:0]        bp_reg, bp_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [CIDX-1:0]      cnt_reg, cnt_next;
    logic                 ok_reg, ok_next;
    logic                 scan_v_reg, scan_v_next;
    logic [FREE_BITS-1:0] fc_reg, fc_next;
    logic                 sweep_out_reg, sweep_out_next;
    logic                 res_bit_reg, res_bit_next;
    logic                 res_stat_reg, res_stat_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    scb_pkg::rsp_t        rsp_reg, rsp_next;

    // tag memory: {tag, slot} per chunk
    logic                   tag_we;
    logic [CIDX-1:0]        tag_waddr, tag_raddr;
    logic [SLOT_BITS+1:0]   tag_wdata, tag_rdata;
    // word memory: {slot, word index}
    logic                   word_we;
    logic [WADDR_BITS-1:0]  word_waddr, word_raddr;
    logic [CW-1:0]          word_wdata, word_rdata;
    // free slot stack
    logic                   stk_we;
    logic [SLOT_BITS-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic                   cmd_accept;
    logic [1:0]             tag_q;
    logic [SLOT_BITS-1:0]   slot_q;
    logic                   is_set;
    logic [CW-1:0]          bit_mask;
    logic [CW-1:0]          pattern;
    logic [CW-1:0]          fill_word;

    scb_ram #(.DEPTH(scb_pkg::NUM_CHUNKS), .WIDTH(SLOT_BITS + 2)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    scb_ram #(.DEPTH((1 << SLOT_BITS) * CW), .WIDTH(CW)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    scb_ram #(.DEPTH(POOL_CHUNKS), .WIDTH(SLOT_BITS)) u_free_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign tag_q    = tag_rdata[SLOT_BITS+1:SLOT_BITS];
    assign slot_q   = tag_rdata[SLOT_BITS-1:0];
    assign is_set   = (op_reg == scb_pkg::OP_SET);
    assign bit_mask = {{(CW-1){1'b0}}, 1'b1} << bp_reg;
    // all ones after a set frees the slot as full; all zeros after a clear as empty
    assign pattern  = is_set ? {CW{1'b1}} : {CW{1'b0}};
    assign fill_word = is_set ? (cnt_reg[SB-1:0] == wi_reg ? bit_mask : {CW{1'b0}})
                              : (cnt_reg[SB-1:0] == wi_reg ? ~bit_mask : {CW{1'b1}});

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ci_next        = ci_reg;
        wi_next        = wi_reg;
        bp_next        = bp_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        ok_next        = ok_reg;
        scan_v_next    = 1'b0;
        fc_next        = fc_reg;
        sweep_out_next = sweep_out_reg;
        res_bit_next   = res_bit_reg;
        res_stat_next  = res_stat_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        tag_we     = 1'b0;
        tag_waddr  = ci_reg;
        tag_wdata  = {scb_pkg::TAG_EMPTY, slot_reg};
        tag_raddr  = ci_reg;
        word_we    = 1'b0;
        word_waddr = {slot_reg, wi_reg};
        word_wdata = fill_word;
        word_raddr = {slot_reg, wi_reg};
        stk_we     = 1'b0;
        stk_waddr  = fc_reg[SLOT_BITS-1:0];
        stk_wdata  = slot_reg;
        stk_raddr  = SLOT_BITS'(fc_reg - FREE_BITS'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_next       = cmd.opcode;
                    ci_next       = {cmd.row[scb_pkg::COORD_BITS-1:SB],
                                     cmd.column[scb_pkg::COORD_BITS-1:SB]};
                    wi_next       = cmd.row[SB-1:0];
                    bp_next       = cmd.column[SB-1:0];
                    tag_raddr     = {cmd.row[scb_pkg::COORD_BITS-1:SB],
                                     cmd.column[scb_pkg::COORD_BITS-1:SB]};
                    res_bit_next  = 1'b0;
                    res_stat_next = scb_pkg::STATUS_DONE;
                    cnt_next      = '0;
                    if (cmd.opcode == scb_pkg::OP_WIPE)
                    begin
                        sweep_out_next = 1'b1;
                        state_next     = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                if (op_reg == scb_pkg::OP_GET)
                begin
                    res_bit_next = (tag_q == scb_pkg::TAG_FULL);
                    word_raddr   = {slot_q, wi_reg};
                    state_next   = (tag_q == scb_pkg::TAG_PARTIAL) ? ST_GETW : ST_DONE;
                end
                else if (tag_q == scb_pkg::TAG_PARTIAL)
                begin
                    slot_next  = slot_q;
                    word_raddr = {slot_q, wi_reg};
                    state_next = ST_MODR;
                end
                else if ((is_set && tag_q == scb_pkg::TAG_EMPTY) ||
                         (!is_set && tag_q == scb_pkg::TAG_FULL))
                begin
                    if (fc_reg == '0)
                    begin
                        res_stat_next = scb_pkg::STATUS_DROPPED;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        // take the top of the free stack, then zero or fill it
                        slot_next  = stk_rdata;
                        fc_next    = fc_reg - FREE_BITS'(1);
                        tag_we     = 1'b1;
                        tag_wdata  = {scb_pkg::TAG_PARTIAL, stk_rdata};
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_GETW:
            begin
                res_bit_next = word_rdata[bp_reg];
                state_next   = ST_DONE;
            end
            ST_FILL:
            begin
                // one set or cleared bit in a 64 x 64 chunk can never free the slot
                word_we    = 1'b1;
                word_waddr = {slot_reg, cnt_reg[SB-1:0]};
                cnt_next   = cnt_reg + CIDX'(1);
                if (cnt_reg[SB-1:0] == {SB{1'b1}})
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MODR:
            begin
                word_we    = 1'b1;
                word_wdata = is_set ? (word_rdata | bit_mask) : (word_rdata & ~bit_mask);
                ok_next    = 1'b1;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                word_raddr  = {slot_reg, cnt_reg[SB-1:0]};
                scan_v_next = 1'b1;
                if (scan_v_reg && word_rdata != pattern)
                begin
                    ok_next = 1'b0;
                end
                cnt_next = cnt_reg + CIDX'(1);
                if (cnt_reg[SB-1:0] == {SB{1'b1}})
                begin
                    state_next = ST_SCANE;
                end
            end
            ST_SCANE:
            begin
                if (ok_reg && word_rdata == pattern)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = {is_set ? scb_pkg::TAG_FULL : scb_pkg::TAG_EMPTY, slot_reg};
                    if (fc_reg < FREE_BITS'(POOL_CHUNKS))
                    begin
                        stk_we  = 1'b1;
                        fc_next = fc_reg + FREE_BITS'(1);
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.bit_value = res_bit_reg;
                    rsp_next.status    = res_stat_reg;
                    state_next         = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                // mark every chunk empty and rebuild the free stack in order
                tag_we    = 1'b1;
                tag_waddr = cnt_reg;
                tag_wdata = {scb_pkg::TAG_EMPTY, {SLOT_BITS{1'b0}}};
                if ({1'b0, cnt_reg} < (CIDX + 1)'(POOL_CHUNKS))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = cnt_reg[SLOT_BITS-1:0];
                    stk_wdata = cnt_reg[SLOT_BITS-1:0];
                end
                cnt_next = cnt_reg + CIDX'(1);
                if (cnt_reg == {CIDX{1'b1}})
                begin
                    fc_next    = FREE_BITS'(POOL_CHUNKS);
                    state_next = sweep_out_reg ? ST_DONE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            cnt_reg       <= '0;
            fc_reg        <= '0;
            sweep_out_reg <= 1'b0;
            scan_v_reg    <= 1'b0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fc_reg        <= fc_next;
            sweep_out_reg <= sweep_out_next;
            scan_v_reg    <= scan_v_next;
            ok_reg        <= ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ci_reg       <= ci_next;
        wi_reg       <= wi_next;
        bp_reg       <= bp_next;
        slot_reg     <= slot_next;
        res_bit_reg  <= res_bit_next;
        res_stat_reg <= res_stat_next;
        rsp_reg      <= rsp_next;
    end

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FREE_BITS'(POOL_CHUNKS))
        else $error("free count exceeds pool size");

    a_sweep_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> !word_we)
        else $error("word write during sweep");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> state_reg != ST_IDLE)
        else $error("accepted transaction not started");

endmodule
